>>> rtl/uart_pkg.sv
// ----------------------------------------------------------------------------
// UART register file package
// Shared constants, register codes, payload types and a small helper function
// for the 16550A-style register file and its receive FIFO storage.
// ----------------------------------------------------------------------------
`default_nettype none

package uart_pkg;

    // Receive FIFO geometry.
    localparam int FIFO_DEPTH = 16;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);
    // Head plus count stays below twice the depth.
    localparam int FIFO_SW    = FIFO_AW + 2;

    // Item kinds.
    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_RX    = 2'd2
    } t_op;

    // Register offsets inside the UART window.
    localparam logic [2:0] REG_RBR = 3'd0;
    localparam logic [2:0] REG_IER = 3'd1;
    localparam logic [2:0] REG_IIR = 3'd2;
    localparam logic [2:0] REG_LCR = 3'd3;
    localparam logic [2:0] REG_MCR = 3'd4;
    localparam logic [2:0] REG_LSR = 3'd5;
    localparam logic [2:0] REG_MSR = 3'd6;
    localparam logic [2:0] REG_SCR = 3'd7;

    // Interrupt identification codes, highest priority first.
    localparam logic [3:0] IID_RLS  = 4'h6;
    localparam logic [3:0] IID_TMO  = 4'hC;
    localparam logic [3:0] IID_RDA  = 4'h4;
    localparam logic [3:0] IID_THRE = 4'h2;
    localparam logic [3:0] IID_MS   = 4'h0;
    localparam logic [3:0] IID_NONE = 4'h1;

    // Register bits.
    localparam int LCR_DLAB_BIT = 7;
    localparam int IER_RDI_BIT  = 0;
    localparam int IER_THRI_BIT = 1;
    localparam int IER_RLSI_BIT = 2;
    localparam int IER_MSI_BIT  = 3;
    localparam int MCR_LOOP_BIT = 4;
    localparam int FCR_FE_BIT   = 0;
    localparam int FCR_RFR_BIT  = 1;
    localparam int FCR_XFR_BIT  = 2;

    localparam logic [7:0] LSR_DR   = 8'h01;
    localparam logic [7:0] LSR_OE   = 8'h02;
    localparam logic [7:0] LSR_BI   = 8'h10;
    localparam logic [7:0] LSR_THRE = 8'h20;
    localparam logic [7:0] LSR_TEMT = 8'h40;
    localparam logic [7:0] LSR_ERRS = 8'h1E;

    localparam logic [7:0] FCR_KEEP_MASK = 8'hC9;
    localparam logic [7:0] IIR_FIFO_BITS = 8'hC0;

    // Reset values.
    localparam logic [7:0]  IIR_RESET = 8'h01;
    localparam logic [7:0]  LSR_RESET = 8'h60;
    localparam logic [7:0]  MSR_RESET = 8'hB0;
    localparam logic [15:0] DIV_RESET = 16'h000C;
    localparam logic [4:0]  MCR_RESET = 5'h08;

    // Modem status lines forced by the model of the attached modem.
    localparam logic [3:0] MSR_LINES = 4'hB;

    typedef struct packed {
        logic [1:0]  op;
        logic [2:0]  reg_offset;
        logic [15:0] write_data;
        logic        access_wide;
        logic [7:0]  line_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] read_data;
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       irq;
        logic       rx_ready;
    } t_out_item;

    // Receive trigger level selected by FCR bits 7:6.
    function automatic logic [3:0] trig_level(input logic [1:0] sel);
        logic [3:0] lvl;
        case (sel)
            2'd0:    lvl = 4'd1;
            2'd1:    lvl = 4'd4;
            2'd2:    lvl = 4'd8;
            default: lvl = 4'd14;
        endcase
        return lvl;
    endfunction

endpackage

`default_nettype wire

>>> rtl/uart_ram.sv
// ----------------------------------------------------------------------------
// UART generic RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module uart_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

>>> rtl/uart_16550a_register_file.sv
// ----------------------------------------------------------------------------
// UART 16550A register file
// Bus-visible register set of a 16550A UART with a receive FIFO.
// ----------------------------------------------------------------------------
`default_nettype none

// The block takes one item per clock unless the result side holds off: a
// bus read, a bus write or a byte that arrived from the serial line. Every
// accepted item produces exactly one result carrying the read data, a
// transmitted byte (a THR write sends its byte at once unless loopback is
// on), the interrupt line level and a flag telling whether another line
// byte can be taken. The input is held in an input register, all register
// updates happen in one pass of short logic and the result lands in an
// output register, and the sustained rate is one item per cycle as long
// as the result side keeps taking transfers. The receive FIFO lives in a
// RAM with a registered read port; the port always reads the entry at the
// next head position, and a byte written to that very entry in the same
// cycle is caught by a bypass register, so a FIFO read never waits on the
// RAM. The FIFO needs no clearing pass after reset: its count starts at
// zero and only written entries are ever read.

module uart_16550a_register_file
    import uart_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_item  i_in_item,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_item      o_out_item
);

    // ------------------------------------------------------------------
    // Handshake and pipeline registers
    // ------------------------------------------------------------------
    logic      r_in_valid;
    t_in_item  r_in;
    logic      r_out_valid;
    t_out_item r_out;
    logic      advance;
    logic      in_xfer;

    // An item moves from the input register to the result register when
    // the result register is empty or its transfer completes this cycle.
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;
    assign in_xfer    = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_xfer) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in <= i_in_item;
        end
    end

    // ------------------------------------------------------------------
    // Architectural registers
    // ------------------------------------------------------------------
    logic [7:0]         r_rbr, n_rbr;
    logic [3:0]         r_ier, n_ier;
    logic [7:0]         r_iir, n_iir;
    logic [7:0]         r_lcr, n_lcr;
    logic [7:0]         r_lsr, n_lsr;
    logic [7:0]         r_msr, n_msr;
    logic [15:0]        r_div, n_div;
    logic [4:0]         r_mcr, n_mcr;
    logic [7:0]         r_scr, n_scr;
    logic [7:0]         r_fcr, n_fcr;
    logic [3:0]         r_trig, n_trig;
    logic               r_tmo, n_tmo;
    logic               r_thre_p, n_thre_p;
    logic [FIFO_AW-1:0] r_head, n_head;
    logic [FIFO_CW-1:0] r_count, n_count;

    // FIFO storage and the same-entry bypass.
    logic               fifo_wr_en;
    logic [FIFO_AW-1:0] fifo_tail;
    logic [7:0]         fifo_rd_data;
    logic [7:0]         head_data;
    logic               r_byp_valid;
    logic [7:0]         r_byp_data;

    // Per-item work signals.
    t_out_item          n_out;
    logic [7:0]         wr_byte;
    logic               take;
    logic [7:0]         take_byte;
    logic               fifo_full;
    logic [7:0]         fcr_v;
    logic [7:0]         msr_new;
    logic [3:0]         iid;
    logic [FIFO_SW-1:0] tail_sum;
    logic               dlab;
    logic               fifo_on;

    assign wr_byte = r_in.write_data[7:0];
    assign dlab    = r_lcr[LCR_DLAB_BIT];
    assign fifo_on = r_fcr[FCR_FE_BIT];

    assign fifo_full = (r_count == FIFO_CW'(FIFO_DEPTH));
    assign tail_sum  = FIFO_SW'(r_head) + FIFO_SW'(r_count);
    assign fifo_tail = (tail_sum >= FIFO_SW'(FIFO_DEPTH))
                     ? FIFO_AW'(tail_sum - FIFO_SW'(FIFO_DEPTH))
                     : FIFO_AW'(tail_sum);

    assign head_data = r_byp_valid ? r_byp_data : fifo_rd_data;

    always_comb begin
        n_rbr    = r_rbr;
        n_ier    = r_ier;
        n_iir    = r_iir;
        n_lcr    = r_lcr;
        n_lsr    = r_lsr;
        n_msr    = r_msr;
        n_div    = r_div;
        n_mcr    = r_mcr;
        n_scr    = r_scr;
        n_fcr    = r_fcr;
        n_trig   = r_trig;
        n_tmo    = r_tmo;
        n_thre_p = r_thre_p;
        n_head   = r_head;
        n_count  = r_count;
        n_out    = '0;
        take      = 1'b0;
        take_byte = r_in.line_byte;
        fifo_wr_en = 1'b0;
        fcr_v     = wr_byte;
        msr_new   = r_msr;
        iid       = IID_NONE;

        if (advance) begin
            case (r_in.op)
                OP_READ: begin
                    case (r_in.reg_offset)
                        REG_RBR: begin
                            if (dlab) begin
                                n_out.read_data = r_div[7:0];
                            end else if (fifo_on) begin
                                if (r_count != '0) begin
                                    n_out.read_data = head_data;
                                    n_head = (r_head == FIFO_AW'(FIFO_DEPTH - 1))
                                           ? '0 : r_head + 1'b1;
                                    n_count = r_count - 1'b1;
                                end
                                if (n_count == '0) begin
                                    n_lsr = r_lsr & ~(LSR_DR | LSR_BI);
                                end
                                n_tmo = 1'b0;
                            end else begin
                                n_out.read_data = r_rbr;
                                n_lsr = r_lsr & ~(LSR_DR | LSR_BI);
                            end
                        end
                        REG_IER: begin
                            n_out.read_data = dlab ? r_div[15:8] : {4'b0, r_ier};
                        end
                        REG_IIR: begin
                            n_out.read_data = r_iir;
                            // Reading a THR-empty identification acknowledges it.
                            if (r_iir[2:1] == IID_THRE[2:1]) begin
                                n_thre_p = 1'b0;
                            end
                        end
                        REG_LCR: n_out.read_data = r_lcr;
                        REG_MCR: n_out.read_data = {3'b0, r_mcr};
                        REG_LSR: begin
                            n_out.read_data = r_lsr;
                            n_lsr = r_lsr & ~(LSR_BI | LSR_OE);
                        end
                        REG_MSR: begin
                            if (r_mcr[MCR_LOOP_BIT]) begin
                                n_out.read_data = {r_mcr[3], r_mcr[2], r_mcr[0],
                                                   r_mcr[1], 4'b0};
                            end else begin
                                msr_new = {r_msr[7:4] | MSR_LINES, 4'b0};
                                if (msr_new != r_msr) begin
                                    msr_new[3:0] = msr_new[7:4] ^ r_msr[7:4];
                                    // Trailing edge of RI only.
                                    if (msr_new[2] && !r_msr[6]) begin
                                        msr_new[2] = 1'b0;
                                    end
                                end
                                n_out.read_data = msr_new;
                                n_msr = {msr_new[7:4], 4'b0};
                            end
                        end
                        default: n_out.read_data = r_scr;
                    endcase
                end
                OP_WRITE: begin
                    case (r_in.reg_offset)
                        REG_RBR: begin
                            if (dlab) begin
                                n_div = r_in.access_wide ? r_in.write_data
                                                         : {r_div[15:8], wr_byte};
                            end else begin
                                n_lsr    = r_lsr | LSR_THRE | LSR_TEMT;
                                n_thre_p = 1'b1;
                                if (r_mcr[MCR_LOOP_BIT]) begin
                                    take      = 1'b1;
                                    take_byte = wr_byte;
                                end else begin
                                    n_out.tx_valid = 1'b1;
                                    n_out.tx_byte  = wr_byte;
                                end
                            end
                        end
                        REG_IER: begin
                            if (dlab) begin
                                n_div = {wr_byte, r_div[7:0]};
                            end else begin
                                n_ier = wr_byte[3:0];
                                if (r_ier[IER_THRI_BIT] != wr_byte[IER_THRI_BIT]) begin
                                    n_thre_p = wr_byte[IER_THRI_BIT] && r_lsr[5];
                                end
                            end
                        end
                        REG_IIR: begin
                            // Toggling FIFO enable resets both FIFOs.
                            if (wr_byte[FCR_FE_BIT] != r_fcr[FCR_FE_BIT]) begin
                                fcr_v[FCR_XFR_BIT] = 1'b1;
                                fcr_v[FCR_RFR_BIT] = 1'b1;
                            end
                            if (fcr_v[FCR_RFR_BIT]) begin
                                n_lsr   = r_lsr & ~(LSR_DR | LSR_BI);
                                n_tmo   = 1'b0;
                                n_head  = '0;
                                n_count = '0;
                            end
                            if (fcr_v[FCR_XFR_BIT]) begin
                                n_lsr    = n_lsr | LSR_THRE;
                                n_thre_p = 1'b1;
                            end
                            n_fcr = fcr_v & FCR_KEEP_MASK;
                            if (n_fcr[FCR_FE_BIT]) begin
                                n_iir  = r_iir | IIR_FIFO_BITS;
                                n_trig = trig_level(n_fcr[7:6]);
                            end else begin
                                n_iir = r_iir & ~IIR_FIFO_BITS;
                            end
                        end
                        REG_LCR: n_lcr = wr_byte;
                        REG_MCR: n_mcr = wr_byte[4:0];
                        REG_SCR: n_scr = wr_byte;
                        default: ;
                    endcase
                end
                OP_RX: begin
                    take = 1'b1;
                end
                default: ;
            endcase

            // Receive path, shared by line bytes and loopback transmits.
            if (take) begin
                if (fifo_on) begin
                    if (!fifo_full) begin
                        fifo_wr_en = 1'b1;
                        n_count    = r_count + 1'b1;
                    end else begin
                        n_lsr = n_lsr | LSR_OE;
                    end
                end else begin
                    if (r_lsr[0]) begin
                        n_lsr = n_lsr | LSR_OE;
                    end
                    n_rbr = take_byte;
                end
                n_lsr = n_lsr | LSR_DR;
            end

            if (r_in.op == OP_RX && n_count != '0) begin
                n_tmo = 1'b1;
            end

            // Interrupt priority evaluation on the updated state.
            if (n_ier[IER_RLSI_BIT] && (n_lsr & LSR_ERRS) != '0) begin
                iid = IID_RLS;
            end else if (n_ier[IER_RDI_BIT] && n_tmo) begin
                iid = IID_TMO;
            end else if (n_ier[IER_RDI_BIT] && n_lsr[0] &&
                         (!n_fcr[FCR_FE_BIT] || n_count >= FIFO_CW'(n_trig))) begin
                iid = IID_RDA;
            end else if (n_ier[IER_THRI_BIT] && n_thre_p) begin
                iid = IID_THRE;
            end else if (n_ier[IER_MSI_BIT] && n_msr[3:0] != '0) begin
                iid = IID_MS;
            end
            n_iir = {n_iir[7:4], iid};

            n_out.irq = (iid != IID_NONE);
            if (n_fcr[FCR_FE_BIT]) begin
                n_out.rx_ready = (n_count != FIFO_CW'(FIFO_DEPTH)) &&
                                 (n_count != FIFO_CW'(n_trig));
            end else begin
                n_out.rx_ready = !n_lsr[0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rbr       <= '0;
            r_ier       <= '0;
            r_iir       <= IIR_RESET;
            r_lcr       <= '0;
            r_lsr       <= LSR_RESET;
            r_msr       <= MSR_RESET;
            r_div       <= DIV_RESET;
            r_mcr       <= MCR_RESET;
            r_scr       <= '0;
            r_fcr       <= '0;
            r_trig      <= '0;
            r_tmo       <= 1'b0;
            r_thre_p    <= 1'b0;
            r_head      <= '0;
            r_count     <= '0;
            r_byp_valid <= 1'b0;
        end else begin
            r_rbr       <= n_rbr;
            r_ier       <= n_ier;
            r_iir       <= n_iir;
            r_lcr       <= n_lcr;
            r_lsr       <= n_lsr;
            r_msr       <= n_msr;
            r_div       <= n_div;
            r_mcr       <= n_mcr;
            r_scr       <= n_scr;
            r_fcr       <= n_fcr;
            r_trig      <= n_trig;
            r_tmo       <= n_tmo;
            r_thre_p    <= n_thre_p;
            r_head      <= n_head;
            r_count     <= n_count;
            // The RAM returns old data when its read and write meet.
            r_byp_valid <= fifo_wr_en && (fifo_tail == n_head);
        end
    end

    always_ff @(posedge i_clk) begin
        r_byp_data <= take_byte;
        if (advance) begin
            r_out <= n_out;
        end
    end

    // The read port always looks at the entry that will be the head.
    uart_ram #(
        .WIDTH (8),
        .DEPTH (FIFO_DEPTH)
    ) u_rx_ram (
        .i_clk     (i_clk),
        .i_wr_en   (fifo_wr_en),
        .i_wr_addr (fifo_tail),
        .i_wr_data (take_byte),
        .i_rd_addr (n_head),
        .o_rd_data (fifo_rd_data)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // The FIFO never holds more than its depth.
    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FIFO_CW'(FIFO_DEPTH))
        else $error("receive FIFO count above depth");

    // Without FIFO mode nothing is kept in the FIFO.
    a_fifo_off_empty : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_fcr[FCR_FE_BIT] |-> (r_count == '0))
        else $error("FIFO holds entries while FIFO mode is off");

    // IIR FIFO bits mirror the FIFO enable.
    a_iir_fifo_bits : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_iir[7:6] == {2{r_fcr[FCR_FE_BIT]}})
        else $error("IIR FIFO bits out of step with FCR");

    // A bypass is only armed by a FIFO write in the previous cycle.
    a_bypass_src : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byp_valid |-> $past(fifo_wr_en))
        else $error("bypass armed without a FIFO write");

endmodule

`default_nettype wire

>>> test/uart_16550a_register_file_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UART 16550A register file testbench
// Sends bus reads, bus writes and line bytes through the item channel and
// checks every result against a fixed value or a cycle-free model of the
// register set, the receive FIFO and the interrupt priority, under several
// idle patterns and one long result-side hold-off.
// ----------------------------------------------------------------------------

module uart_16550a_register_file_test;
    import uart_pkg::*;

    // No item kind uses this code. The block must leave its state alone.
    localparam logic [1:0] OP_IDLE = 2'd3;

    localparam int RESET_CYCLES    = 5;
    localparam int ITEMS_PER_PHASE = 340;
    localparam int PHASES          = 5;
    localparam int PRESSURE_PHASE  = 4;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int QUIET_LIMIT     = 4000;
    localparam int DRAIN_CYCLES    = 8;

    // Idle percentages per phase: none, sender, receiver, both, then the
    // phase that opens with a long receiver hold-off.
    localparam int SEND_IDLE_PCT  [PHASES] = '{0, 46, 0, 26, 0};
    localparam int RECV_STALL_PCT [PHASES] = '{0, 0, 46, 26, 0};

    // Receive trigger levels selected by FCR bits 7:6.
    localparam logic [3:0] TRIGGER_STEPS [4] = '{4'd1, 4'd4, 4'd8, 4'd14};

    typedef struct packed {
        t_in_item  item;
        logic      typed;
        t_out_item want;
    } t_script_row;

    // Directed opening. Rows with typed set carry a result that is plain from
    // the reset values or the extremes; the others are checked by the model.
    localparam int SCRIPT_LEN = 29;
    localparam t_script_row SCRIPT [SCRIPT_LEN] = '{
        // Reset values of LSR, IIR and MSR.
        '{'{OP_READ,  REG_LSR, 16'h0000, 1'b0, 8'h00}, 1'b1, '{8'h60, 1'b0, 8'h00, 1'b0, 1'b1}},
        '{'{OP_READ,  REG_IIR, 16'h0000, 1'b0, 8'h00}, 1'b1, '{8'h01, 1'b0, 8'h00, 1'b0, 1'b1}},
        '{'{OP_READ,  REG_MSR, 16'h0000, 1'b0, 8'h00}, 1'b1, '{8'hB0, 1'b0, 8'h00, 1'b0, 1'b1}},
        // Unused item kind with every other field at its top.
        '{'{OP_IDLE,  REG_SCR, 16'hFFFF, 1'b1, 8'hFF}, 1'b1, '{8'h00, 1'b0, 8'h00, 1'b0, 1'b1}},
        // THR writes go out on the line at once; a wide one sends its low byte.
        '{'{OP_WRITE, REG_RBR, 16'h00FF, 1'b0, 8'h00}, 1'b1, '{8'h00, 1'b1, 8'hFF, 1'b0, 1'b1}},
        '{'{OP_WRITE, REG_RBR, 16'hAA00, 1'b1, 8'h00}, 1'b1, '{8'h00, 1'b1, 8'h00, 1'b0, 1'b1}},
        // Divisor latch: wide write, read back, byte writes to both halves.
        '{'{OP_WRITE, REG_LCR, 16'h0080, 1'b0, 8'h00}, 1'b0, '0},
        '{'{OP_WRITE, REG_RBR, 16'hFFFF, 1'b1, 8'h00}, 1'b0, '0},
        '{'{OP_READ,  REG_RBR, 16'h0000, 1'b0, 8'h00}, 1'b1, '{8'hFF, 1'b0, 8'h00, 1'b0, 1'b1}},
        '{'{OP_READ,  REG_IER, 16'h0000, 1'b0, 8'h00}, 1'b1, '{8'hFF, 1'b0, 8'h00, 1'b0, 1'b1}},
        '{'{OP_WRITE, REG_IER, 16'h0001, 1'b0, 8'h00}, 1'b0, '0},
        '{'{OP_WRITE, REG_RBR, 16'h3412, 1'b0, 8'h00}, 1'b0, '0},
        '{'{OP_WRITE, REG_LCR, 16'h0003, 1'b0, 8'h00}, 1'b0, '0},
        // Writes to the read-only offsets LSR and MSR change nothing, then SCR is written.
        '{'{OP_WRITE, REG_LSR, 16'hFFFF, 1'b0, 8'h00}, 1'b0, '0},
        '{'{OP_WRITE, REG_MSR, 16'hFFFF, 1'b0, 8'h00}, 1'b0, '0},
        '{'{OP_WRITE, REG_SCR, 16'h00FF, 1'b0, 8'h00}, 1'b0, '0},
        // Every interrupt enabled, THR empty fires and is cleared by an IIR read.
        '{'{OP_WRITE, REG_IER, 16'h000F, 1'b0, 8'h00}, 1'b0, '0},
        '{'{OP_READ,  REG_IIR, 16'h0000, 1'b0, 8'h00}, 1'b0, '0},
        // FIFO on at trigger level 14, then a read of the empty FIFO.
        '{'{OP_WRITE, REG_IIR, 16'h00C7, 1'b0, 8'h00}, 1'b0, '0},
        '{'{OP_READ,  REG_RBR, 16'h0000, 1'b0, 8'h00}, 1'b0, '0},
        '{'{OP_RX,    REG_RBR, 16'h0000, 1'b0, 8'hFF}, 1'b0, '0},
        '{'{OP_RX,    REG_RBR, 16'h0000, 1'b0, 8'h00}, 1'b0, '0},
        '{'{OP_READ,  REG_RBR, 16'h0000, 1'b0, 8'h00}, 1'b0, '0},
        // Loopback: the THR byte lands in the FIFO, MSR mirrors MCR.
        '{'{OP_WRITE, REG_MCR, 16'h001F, 1'b0, 8'h00}, 1'b0, '0},
        '{'{OP_WRITE, REG_RBR, 16'h005A, 1'b0, 8'h00}, 1'b0, '0},
        '{'{OP_READ,  REG_MSR, 16'h0000, 1'b0, 8'h00}, 1'b0, '0},
        // FIFO off, then a second line byte onto a full RBR raises overrun.
        '{'{OP_WRITE, REG_IIR, 16'h0000, 1'b0, 8'h00}, 1'b0, '0},
        '{'{OP_RX,    REG_RBR, 16'h0000, 1'b0, 8'h11}, 1'b0, '0},
        '{'{OP_RX,    REG_RBR, 16'h0000, 1'b0, 8'h22}, 1'b0, '0}
    };

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_item  i_in_item;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_item o_out_item;

    // Results owed by the block, oldest first.
    t_out_item replies_due[$];

    int mismatch_count = 0;
    int quiet_cycles   = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int rx_burst_left  = 0;
    bit hold_off_request = 1'b0;

    // Register set as the bus and the line see it.
    logic [7:0]  rbr;
    logic [3:0]  ier;
    logic [7:0]  iir;
    logic [7:0]  lcr;
    logic [7:0]  lsr;
    logic [7:0]  msr;
    logic [15:0] divisor;
    logic [4:0]  mcr;
    logic [7:0]  scr;
    logic [7:0]  fcr;
    logic [3:0]  rx_trigger;
    logic        rx_timeout_pend;
    logic        thr_empty_pend;
    logic [7:0]  rx_fifo [FIFO_DEPTH];
    int unsigned rx_head;
    int unsigned rx_count;

    uart_16550a_register_file uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_item (o_out_item)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // A byte from the line or from loopback. A full FIFO drops it, a full
    // RBR is overwritten; both raise overrun.
    function automatic void take_line_byte(input logic [7:0] b);
        if (fcr[FCR_FE_BIT]) begin
            if (rx_count < FIFO_DEPTH) begin
                rx_fifo[(rx_head + rx_count) % FIFO_DEPTH] = b;
                rx_count++;
            end else begin
                lsr |= LSR_OE;
            end
        end else begin
            if ((lsr & LSR_DR) != 8'h00)
                lsr |= LSR_OE;
            rbr = b;
        end
        lsr |= LSR_DR;
    endfunction

    // Applies one item to the register set and returns its result.
    function automatic t_out_item step_uart_regs(input t_in_item it);
        t_out_item  res;
        logic [7:0] v;
        logic [7:0] fc;
        logic [7:0] old_msr;
        logic [3:0] ier_flips;
        logic [3:0] iid;
        res = '0;
        v = it.write_data[7:0];
        case (it.op)
            OP_READ: begin
                case (it.reg_offset)
                    REG_RBR: begin
                        if (lcr[LCR_DLAB_BIT]) begin
                            res.read_data = divisor[7:0];
                        end else if (fcr[FCR_FE_BIT]) begin
                            if (rx_count != 0) begin
                                res.read_data = rx_fifo[rx_head];
                                rx_head = (rx_head + 1) % FIFO_DEPTH;
                                rx_count--;
                            end
                            if (rx_count == 0)
                                lsr &= ~(LSR_DR | LSR_BI);
                            rx_timeout_pend = 1'b0;
                        end else begin
                            res.read_data = rbr;
                            lsr &= ~(LSR_DR | LSR_BI);
                        end
                    end
                    REG_IER: res.read_data = lcr[LCR_DLAB_BIT] ? divisor[15:8] : {4'h0, ier};
                    REG_IIR: begin
                        res.read_data = iir;
                        // Reading the THR-empty identification clears it.
                        if (iir[2:1] == IID_THRE[2:1])
                            thr_empty_pend = 1'b0;
                    end
                    REG_LCR: res.read_data = lcr;
                    REG_MCR: res.read_data = {3'b000, mcr};
                    REG_LSR: begin
                        res.read_data = lsr;
                        lsr &= ~(LSR_BI | LSR_OE);
                    end
                    REG_MSR: begin
                        if (mcr[MCR_LOOP_BIT]) begin
                            res.read_data = {mcr[3], mcr[2], mcr[0], mcr[1], 4'h0};
                        end else begin
                            old_msr = msr;
                            msr = {msr[7:4] | MSR_LINES, 4'h0};
                            if (msr != old_msr) begin
                                msr[3:0] = msr[7:4] ^ old_msr[7:4];
                                if (msr[2] && !old_msr[6])
                                    msr[2] = 1'b0;
                            end
                            res.read_data = msr;
                            msr[3:0] = 4'h0;
                        end
                    end
                    default: res.read_data = scr;
                endcase
            end
            OP_WRITE: begin
                case (it.reg_offset)
                    REG_RBR: begin
                        if (lcr[LCR_DLAB_BIT]) begin
                            divisor = it.access_wide ? it.write_data : {divisor[15:8], v};
                        end else begin
                            lsr |= LSR_THRE;
                            thr_empty_pend = 1'b1;
                            if (mcr[MCR_LOOP_BIT]) begin
                                take_line_byte(v);
                            end else begin
                                res.tx_valid = 1'b1;
                                res.tx_byte  = v;
                            end
                            lsr |= LSR_TEMT;
                        end
                    end
                    REG_IER: begin
                        if (lcr[LCR_DLAB_BIT]) begin
                            divisor[15:8] = v;
                        end else begin
                            ier_flips = ier ^ v[3:0];
                            ier = v[3:0];
                            if (ier_flips[IER_THRI_BIT])
                                thr_empty_pend = ier[IER_THRI_BIT] && ((lsr & LSR_THRE) != 8'h00);
                        end
                    end
                    REG_IIR: begin
                        // Toggling the FIFO enable resets both FIFOs.
                        fc = v;
                        if (fc[FCR_FE_BIT] != fcr[FCR_FE_BIT]) begin
                            fc[FCR_RFR_BIT] = 1'b1;
                            fc[FCR_XFR_BIT] = 1'b1;
                        end
                        if (fc[FCR_RFR_BIT]) begin
                            lsr &= ~(LSR_DR | LSR_BI);
                            rx_timeout_pend = 1'b0;
                            rx_head = 0;
                            rx_count = 0;
                        end
                        if (fc[FCR_XFR_BIT]) begin
                            lsr |= LSR_THRE;
                            thr_empty_pend = 1'b1;
                        end
                        fcr = fc & FCR_KEEP_MASK;
                        if (fcr[FCR_FE_BIT]) begin
                            iir |= IIR_FIFO_BITS;
                            rx_trigger = TRIGGER_STEPS[fcr[7:6]];
                        end else begin
                            iir &= ~IIR_FIFO_BITS;
                        end
                    end
                    REG_LCR: lcr = v;
                    REG_MCR: mcr = v[4:0];
                    REG_SCR: scr = v;
                    default: ;
                endcase
            end
            OP_RX: begin
                take_line_byte(it.line_byte);
                if (rx_count != 0)
                    rx_timeout_pend = 1'b1;
            end
            default: ;
        endcase

        // Interrupt identification, highest priority first.
        iid = IID_NONE;
        if (ier[IER_RLSI_BIT] && (lsr & LSR_ERRS) != 8'h00)
            iid = IID_RLS;
        else if (ier[IER_RDI_BIT] && rx_timeout_pend)
            iid = IID_TMO;
        else if (ier[IER_RDI_BIT] && (lsr & LSR_DR) != 8'h00 &&
                 (!fcr[FCR_FE_BIT] || rx_count >= rx_trigger))
            iid = IID_RDA;
        else if (ier[IER_THRI_BIT] && thr_empty_pend)
            iid = IID_THRE;
        else if (ier[IER_MSI_BIT] && msr[3:0] != 4'h0)
            iid = IID_MS;
        iir = {iir[7:4], iid};
        res.irq = (iid != IID_NONE);

        // In FIFO mode the line side backs off when full or at the trigger.
        if (fcr[FCR_FE_BIT])
            res.rx_ready = (rx_count < FIFO_DEPTH) && (rx_count != rx_trigger);
        else
            res.rx_ready = ((lsr & LSR_DR) == 8'h00);
        return res;
    endfunction

    // Random item. Runs of line bytes fill the FIFO past its trigger and into
    // overrun; LCR and FCR writes mostly keep the divisor latch closed and the
    // FIFO on so that RBR reads mostly reach the receive path.
    function automatic t_in_item draw_uart_item();
        t_in_item    it;
        int unsigned pick;
        it.op          = OP_READ;
        it.reg_offset  = 3'($urandom_range(7, 0));
        it.write_data  = 16'($urandom_range(16'hFFFF, 0));
        it.access_wide = 1'($urandom_range(1, 0));
        it.line_byte   = 8'($urandom_range(255, 0));
        pick = $urandom_range(99, 0);
        if (rx_burst_left != 0) begin
            rx_burst_left--;
            it.op = OP_RX;
        end else if (pick < 2) begin
            rx_burst_left = $urandom_range(24, 8);
            it.op = OP_RX;
        end else if (pick < 5) begin
            it.op = OP_IDLE;
        end else if (pick < 35) begin
            it.op = OP_RX;
        end else if (pick < 68) begin
            it.op = OP_READ;
            if (pick < 50)
                it.reg_offset = REG_RBR;
        end else begin
            it.op = OP_WRITE;
            case (it.reg_offset)
                REG_LCR: if (pick < 92) it.write_data[LCR_DLAB_BIT] = 1'b0;
                REG_IIR: if (pick < 92) it.write_data[FCR_FE_BIT] = 1'b1;
                REG_MCR: if (pick < 85) it.write_data[MCR_LOOP_BIT] = 1'b0;
                default: ;
            endcase
        end
        return it;
    endfunction

    // Offers one item and returns at the edge where its transfer happens.
    // Valid stays high into the next item unless the sender idles.
    task automatic offer_item(input t_in_item it);
        while ($urandom_range(99, 0) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
    endtask

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    // Item side: reset, directed rows, then the random phases.
    initial begin : item_side
        t_in_item  it;
        t_out_item predicted;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_item  <= '0;

        rbr             = '0;
        ier             = '0;
        iir             = IIR_RESET;
        lcr             = '0;
        lsr             = LSR_RESET;
        msr             = MSR_RESET;
        divisor         = DIV_RESET;
        mcr             = MCR_RESET;
        scr             = '0;
        fcr             = '0;
        rx_trigger      = '0;
        rx_timeout_pend = 1'b0;
        thr_empty_pend  = 1'b0;
        rx_head         = 0;
        rx_count        = 0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int n = 0; n < SCRIPT_LEN; n++) begin
            offer_item(SCRIPT[n].item);
            predicted = step_uart_regs(SCRIPT[n].item);
            replies_due.push_back(SCRIPT[n].typed ? SCRIPT[n].want : predicted);
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            send_idle_pct  = SEND_IDLE_PCT[ph];
            recv_stall_pct = RECV_STALL_PCT[ph];
            // The receiver holds off while items keep coming, so the block
            // fills up and has to refuse transfers.
            if (ph == PRESSURE_PHASE)
                hold_off_request = 1'b1;
            repeat (ITEMS_PER_PHASE) begin
                it = draw_uart_item();
                offer_item(it);
                replies_due.push_back(step_uart_regs(it));
            end
        end
        i_in_valid <= 1'b0;

        while (replies_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && replies_due.size() == 0)
            $display("uart_16550a_register_file: match");
        else
            $display("uart_16550a_register_file: mismatch");
        $finish;
    end

    // Result side: checks each result transfer and decides ready for the
    // next edge, including the long hold-off counted here.
    initial begin : result_side
        t_out_item   want;
        int unsigned hold_left;
        hold_left = 0;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && i_out_ready && o_out_valid) begin
                if (replies_due.size() == 0) begin
                    $display("%0t: result %h arrived with nothing outstanding",
                             $time, o_out_item);
                    mismatch_count++;
                end else begin
                    want = replies_due.pop_front();
                    check_field("read_data", want.read_data, o_out_item.read_data);
                    check_field("tx_valid", 8'(want.tx_valid), 8'(o_out_item.tx_valid));
                    check_field("tx_byte", want.tx_byte, o_out_item.tx_byte);
                    check_field("irq", 8'(want.irq), 8'(o_out_item.irq));
                    check_field("rx_ready", 8'(want.rx_ready), 8'(o_out_item.rx_ready));
                end
            end
            if (!i_rst_n) begin
                i_out_ready <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (hold_off_request) begin
                hold_off_request = 1'b0;
                hold_left = HOLD_OFF_CYCLES - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99, 0) >= recv_stall_pct);
            end
        end
    end

    // Watchdog: too long without any transfer on either side ends the run.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("uart_16550a_register_file: mismatch");
            $finish;
        end
    end

endmodule
